[rtl/sfcd_pkg.sv]
// shared constants and types of the sensor frame crc check and decode unit
`default_nettype none
package sfcd_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // frame positions
   localparam logic [2:0] IDX_TEMP_HI  = 3'd2;
   localparam logic [2:0] IDX_TEMP_LO  = 3'd3;
   localparam logic [2:0] IDX_CRC_LO   = 3'd4;
   localparam logic [2:0] IDX_CRC_HI   = 3'd5;

   localparam logic [7:0]  FAIL_MAX           = 8'hFF;
   localparam logic [7:0]  RETRY_LIMIT_RESET  = 8'd11;
   localparam logic [15:0] FALLBACK_RESET     = 16'd4660;

   // csr register indexes
   localparam logic CSR_RETRY_LIMIT = 1'b0;
   localparam logic CSR_FALLBACK    = 1'b1;

   typedef struct packed {
      logic [15:0] crc;
      logic [7:0]  data;
   } crc_req_type;

endpackage
`default_nettype wire

[rtl/sfcd_crc_byte.sv]
// reflected crc-16 update over one byte, lsb first
`default_nettype none
module sfcd_crc_byte (
   input  wire sfcd_pkg::crc_req_type crc_req,
   output logic [15:0]                crc_out
);

   logic [15:0] c;

   always_comb begin
      c = crc_req.crc ^ {8'h00, crc_req.data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ sfcd_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule
`default_nettype wire

[rtl/sensor_frame_crc_check_decode_unit.sv]
// top level of the sensor frame crc check and decode unit
// Takes a six-byte sensor reply one byte per beat on the req channel and
// checks a reflected crc-16 (init 0xFFFF, poly 0xA001) over bytes 0..3 against
// bytes 4 and 5, low byte first. Every byte is taken at once: the
// eight-bit crc update is one combinational pass between the frame state
// registers and the result register, so a byte can be accepted every clock
// as long as the result register is empty or being drained in that cycle.
// The last byte of a frame gives a result in the next cycle when the crc
// matches (decoded temperature in tenths) or when the failure count passes
// retry_limit (fallback value with gave_up set); other bytes give no result.
// Raise req_new_measurement on the first byte of a measurement to clear the
// failure count and restart framing. Csr writes are taken at once and should
// only be made while the block is idle.
`default_nettype none
module sensor_frame_crc_check_decode_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_rx_byte,
   input  wire         req_new_measurement,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic signed [15:0] rsp_temp_tenths,
   output logic        rsp_crc_ok,
   output logic        rsp_gave_up,
   output logic [7:0]  rsp_failures,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [15:0] csr_wdata
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [15:0] temp_bytes_ff, temp_bytes_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [7:0]  fail_count_ff, fail_count_in;
   logic [7:0]  retry_limit_ff;
   logic [15:0] fallback_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_temp_ff, rsp_temp_in;
   logic        rsp_crc_ok_ff, rsp_crc_ok_in;
   logic        rsp_gave_up_ff, rsp_gave_up_in;
   logic [7:0]  rsp_failures_ff, rsp_failures_in;

   sfcd_pkg::crc_req_type crc_req;
   logic [15:0] crc_next;
   logic        accept;
   logic [2:0]  idx;
   logic [15:0] crc_cur;
   logic [7:0]  fail_cur, fail_sat;
   logic [15:0] mag;
   logic        crc_match;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign crc_cur  = req_new_measurement ? sfcd_pkg::CRC_INIT : crc_ff;
   assign fail_cur = req_new_measurement ? 8'd0 : fail_count_ff;
   assign fail_sat = (fail_cur == sfcd_pkg::FAIL_MAX) ? fail_cur : fail_cur + 8'd1;

   always_comb begin
      idx = req_new_measurement ? 3'd0 : byte_index_ff;
      if (idx > sfcd_pkg::IDX_CRC_HI) begin
         idx = 3'd0;
      end
   end

   assign crc_req.crc  = crc_cur;
   assign crc_req.data = req_rx_byte;

   sfcd_crc_byte u_crc (
      .crc_req (crc_req),
      .crc_out (crc_next)
   );

   // sign-magnitude to two's complement, negative zero gives zero
   assign mag       = {1'b0, temp_bytes_ff[14:0]};
   assign crc_match = ({req_rx_byte, crc_low_ff} == crc_cur);

   always_comb begin
      crc_in          = crc_ff;
      byte_index_in   = byte_index_ff;
      temp_bytes_in   = temp_bytes_ff;
      crc_low_in      = crc_low_ff;
      fail_count_in   = fail_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_temp_in     = rsp_temp_ff;
      rsp_crc_ok_in   = rsp_crc_ok_ff;
      rsp_gave_up_in  = rsp_gave_up_ff;
      rsp_failures_in = rsp_failures_ff;
      if (accept) begin
         fail_count_in = fail_cur;
         if (idx < sfcd_pkg::IDX_CRC_LO) begin
            crc_in        = crc_next;
            byte_index_in = idx + 3'd1;
            if (idx == sfcd_pkg::IDX_TEMP_HI) begin
               temp_bytes_in[15:8] = req_rx_byte;
            end else if (idx == sfcd_pkg::IDX_TEMP_LO) begin
               temp_bytes_in[7:0] = req_rx_byte;
            end
         end else if (idx == sfcd_pkg::IDX_CRC_LO) begin
            crc_in        = crc_cur;
            crc_low_in    = req_rx_byte;
            byte_index_in = sfcd_pkg::IDX_CRC_HI;
         end else begin
            // last byte of the frame
            crc_in        = sfcd_pkg::CRC_INIT;
            byte_index_in = 3'd0;
            if (crc_match) begin
               rsp_valid_in    = 1'b1;
               rsp_temp_in     = temp_bytes_ff[15] ? 16'd0 - mag : mag;
               rsp_crc_ok_in   = 1'b1;
               rsp_gave_up_in  = 1'b0;
               rsp_failures_in = fail_cur;
               fail_count_in   = 8'd0;
            end else if (fail_sat > retry_limit_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_temp_in     = fallback_ff;
               rsp_crc_ok_in   = 1'b0;
               rsp_gave_up_in  = 1'b1;
               rsp_failures_in = fail_sat;
               fail_count_in   = 8'd0;
            end else begin
               fail_count_in = fail_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= sfcd_pkg::CRC_INIT;
         byte_index_ff  <= 3'd0;
         temp_bytes_ff  <= 16'd0;
         crc_low_ff     <= 8'd0;
         fail_count_ff  <= 8'd0;
         rsp_valid_ff   <= 1'b0;
         retry_limit_ff <= sfcd_pkg::RETRY_LIMIT_RESET;
         fallback_ff    <= sfcd_pkg::FALLBACK_RESET;
      end else begin
         crc_ff        <= crc_in;
         byte_index_ff <= byte_index_in;
         temp_bytes_ff <= temp_bytes_in;
         crc_low_ff    <= crc_low_in;
         fail_count_ff <= fail_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               sfcd_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[7:0];
               sfcd_pkg::CSR_FALLBACK:    fallback_ff    <= csr_wdata;
               default:                   retry_limit_ff <= retry_limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff     <= rsp_temp_in;
      rsp_crc_ok_ff   <= rsp_crc_ok_in;
      rsp_gave_up_ff  <= rsp_gave_up_in;
      rsp_failures_ff <= rsp_failures_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_tenths = rsp_temp_ff;
   assign rsp_crc_ok      = rsp_crc_ok_ff;
   assign rsp_gave_up     = rsp_gave_up_ff;
   assign rsp_failures    = rsp_failures_ff;

endmodule
`default_nettype wire

[rtl/sfcd_checker.sv]
// port-level checks of the sensor frame crc check and decode unit, with bind
`default_nettype none
module sfcd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_temp_tenths,
   input wire        rsp_crc_ok,
   input wire        rsp_gave_up,
   input wire [7:0]  rsp_failures
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_tenths)
         && $stable(rsp_crc_ok) && $stable(rsp_gave_up) && $stable(rsp_failures))
      else $error("stalled result beat changed");

   // a result is either a good frame or a give-up, never both or neither
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_crc_ok != rsp_gave_up))
      else $error("result flags inconsistent");

   // giving up needs at least one failed frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gave_up |-> rsp_failures != 8'd0)
      else $error("gave up with no failures");

   // a new result only follows an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

   // input is not refused while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind sensor_frame_crc_check_decode_unit sfcd_checker u_sfcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_temp_tenths (rsp_temp_tenths),
   .rsp_crc_ok      (rsp_crc_ok),
   .rsp_gave_up     (rsp_gave_up),
   .rsp_failures    (rsp_failures)
);
`default_nettype wire

[test/tb_sensor_frame_crc_check_decode_unit.sv]
// testbench of the sensor frame crc check and decode unit with its own frame predictor
`timescale 1ns / 1ps
module tb_sensor_frame_crc_check_decode_unit;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_meas;
   } rx_beat_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic               crc_ok;
      logic               gave_up;
      logic [7:0]         failures;
   } temp_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_new_measurement = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [15:0] rsp_temp_tenths;
   logic        rsp_crc_ok;
   logic        rsp_gave_up;
   logic [7:0]  rsp_failures;
   logic        csr_we = 1'b0;
   logic        csr_index = sfcd_pkg::CSR_RETRY_LIMIT;
   logic [15:0] csr_wdata = 16'h0000;

   // pending beats for the driver and reports still owed by the block
   rx_beat_type     frame_bytes[$];
   temp_report_type temp_reports[$];
   int bytes_queued = 0;
   int bytes_accepted = 0;
   int mismatches = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit restart_due = 1'b0;

   // predictor state and its copy of the csr settings
   logic [15:0] crc_state = sfcd_pkg::CRC_INIT;
   logic [2:0]  frame_pos = 3'd0;
   logic [15:0] temp_raw = 16'h0000;
   logic [7:0]  crc_lo_rx = 8'h00;
   logic [7:0]  fail_cnt = 8'h00;
   logic [7:0]  retry_lim = sfcd_pkg::RETRY_LIMIT_RESET;
   logic [15:0] fallback = sfcd_pkg::FALLBACK_RESET;

   sensor_frame_crc_check_decode_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_new_measurement (req_new_measurement),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_temp_tenths     (rsp_temp_tenths),
      .rsp_crc_ok          (rsp_crc_ok),
      .rsp_gave_up         (rsp_gave_up),
      .rsp_failures        (rsp_failures),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ sfcd_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // sign-magnitude temperature bytes to two's complement tenths
   function automatic logic [15:0] sign_mag_to_tenths(logic [15:0] raw);
      logic [15:0] mag;
      mag = {1'b0, raw[14:0]};
      return raw[15] ? (~mag + 16'd1) : mag;
   endfunction

   task automatic predict_byte(input logic [7:0] rx, input logic start);
      logic [2:0]      pos;
      temp_report_type rep;
      if (start) begin
         fail_cnt  = 8'h00;
         frame_pos = 3'd0;
         crc_state = sfcd_pkg::CRC_INIT;
      end
      pos = (frame_pos > sfcd_pkg::IDX_CRC_HI) ? 3'd0 : frame_pos;
      if (pos < sfcd_pkg::IDX_CRC_LO) begin
         crc_state = crc16_step(crc_state, rx);
         if (pos == sfcd_pkg::IDX_TEMP_HI) temp_raw[15:8] = rx;
         else if (pos == sfcd_pkg::IDX_TEMP_LO) temp_raw[7:0] = rx;
         frame_pos = pos + 3'd1;
      end else if (pos == sfcd_pkg::IDX_CRC_LO) begin
         crc_lo_rx = rx;
         frame_pos = sfcd_pkg::IDX_CRC_HI;
      end else begin
         frame_pos = 3'd0;
         if ({rx, crc_lo_rx} == crc_state) begin
            rep.temp_tenths = sign_mag_to_tenths(temp_raw);
            rep.crc_ok      = 1'b1;
            rep.gave_up     = 1'b0;
            rep.failures    = fail_cnt;
            temp_reports.push_back(rep);
            fail_cnt = 8'h00;
         end else begin
            if (fail_cnt != sfcd_pkg::FAIL_MAX) fail_cnt = fail_cnt + 8'd1;
            if (fail_cnt > retry_lim) begin
               rep.temp_tenths = fallback;
               rep.crc_ok      = 1'b0;
               rep.gave_up     = 1'b1;
               rep.failures    = fail_cnt;
               temp_reports.push_back(rep);
               fail_cnt = 8'h00;
            end
         end
         crc_state = sfcd_pkg::CRC_INIT;
      end
   endtask

   task automatic check_report();
      temp_report_type want;
      if (temp_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: temp %0d crc_ok %0b gave_up %0b failures %0d",
                     rsp_temp_tenths, rsp_crc_ok, rsp_gave_up, rsp_failures);
      end else begin
         want = temp_reports.pop_front();
         if (rsp_temp_tenths !== want.temp_tenths || rsp_crc_ok !== want.crc_ok ||
             rsp_gave_up !== want.gave_up || rsp_failures !== want.failures) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected temp %0d crc_ok %0b gave_up %0b failures %0d",
                        $signed(want.temp_tenths), want.crc_ok, want.gave_up,
                        want.failures,
                        ", got temp %0d crc_ok %0b gave_up %0b failures %0d",
                        rsp_temp_tenths, rsp_crc_ok, rsp_gave_up, rsp_failures);
         end
      end
   endtask

   // driver: one beat from the pending queue whenever the channel is free, unless it idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte(req_rx_byte, req_new_measurement);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (frame_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid           <= 1'b1;
               req_rx_byte         <= frame_bytes[0].rx_byte;
               req_new_measurement <= frame_bytes[0].new_meas;
               frame_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_report();
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic start);
      rx_beat_type beat;
      beat.rx_byte  = b;
      beat.new_meas = start;
      frame_bytes.push_back(beat);
      bytes_queued++;
   endtask

   // six-byte frame with its crc, optionally with one bit flipped anywhere
   task automatic queue_frame(input logic [7:0] b0, b1, b2, b3, input logic start,
                              input bit corrupt);
      logic [15:0] crc;
      logic [47:0] frame;
      crc = crc16_step(crc16_step(crc16_step(crc16_step(sfcd_pkg::CRC_INIT, b0), b1),
                                  b2), b3);
      frame = {crc[15:8], crc[7:0], b3, b2, b1, b0};
      if (corrupt) frame[$urandom_range(47)] ^= 1'b1;
      for (int i = 0; i < 6; i++) push_byte(frame[8*i +: 8], (i == 0) ? start : 1'b0);
   endtask

   task automatic random_traffic(input int count, input int good_pct);
      int goal;
      int pick;
      int n;
      logic [7:0] hi;
      logic [7:0] extremes [4];
      extremes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      goal = bytes_queued + count;
      while (bytes_queued < goal) begin
         pick = $urandom_range(99);
         hi = ($urandom_range(5) == 0) ? extremes[$urandom_range(3)] : 8'($urandom_range(255));
         if (pick < 90) begin
            queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), hi,
                        8'($urandom_range(255)), restart_due || ($urandom_range(7) == 0),
                        pick >= good_pct);
            restart_due = 1'b0;
         end else if (pick < 96) begin
            // frame cut short, the next one restarts the measurement
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
               push_byte(8'($urandom_range(255)), (i == 0) ? restart_due : 1'b0);
            restart_due = 1'b1;
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            restart_due = 1'b1;
         end
      end
   endtask

   // sender holds off until the block has nothing left in flight
   task automatic settle();
      while (bytes_accepted != bytes_queued || temp_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sfcd_pkg::CSR_RETRY_LIMIT) retry_lim = data[7:0];
      else fallback = data;
   endtask

   task automatic apply_settings(input logic [7:0] limit, input logic [15:0] fb);
      write_csr(sfcd_pkg::CSR_RETRY_LIMIT, {8'h00, limit});
      write_csr(sfcd_pkg::CSR_FALLBACK, fb);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct   = 21;
      receiver_idle_pct = 60;

      // give up on the first bad frame, fallback of -32767
      apply_settings(8'd0, 16'h8001);
      queue_frame(8'h00, 8'h00, 8'h7F, 8'hFF, 1'b1, 1'b0);
      queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
      // negative zero
      queue_frame(8'h01, 8'h04, 8'h80, 8'h00, 1'b0, 1'b0);
      queue_frame(8'h01, 8'h04, 8'h00, 8'hC8, 1'b0, 1'b1);
      settle();

      apply_settings(8'd3, 16'h7FFF);
      random_traffic(610, 35);
      settle();

      sender_idle_pct   = 60;
      receiver_idle_pct = 21;
      // limit of 255 never gives up
      apply_settings(8'd255, 16'h0000);
      random_traffic(610, 55);
      settle();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      apply_settings(8'd1, 16'hFFFF);
      random_traffic(610, 45);
      settle();

      mismatches += temp_reports.size();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
